// ===== rtl/core/tsq_pkg.sv =====
// shared types and constants for the thread status queues block
// no dependencies; used by thread_status_queues_unit
package tsq_pkg;

  // default sizing
  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;

  // fixed field widths
  localparam int MODE_W   = 3;
  localparam int QSEL_W   = 3;
  localparam int KEY_W    = 8;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int LIMIT_W  = 5;
  localparam int WORD_W   = KEY_W + HANDLE_W;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ    = 3'd0,
    MODE_DEQ    = 3'd1,
    MODE_PEEK   = 3'd2,
    MODE_LOOKUP = 3'd3,
    MODE_PULL   = 3'd4
  } mode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_INVALID   = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/core/thread_status_queues_unit.sv =====
// thread status queues: per-status fifo queues of {thread id, handle} entries
// depends on tsq_pkg; holds the entry memory and the operation sequencer
//
// One fifo queue of thread entries per thread status, all sharing one entry
// memory of NUM_QUEUES x QUEUE_DEPTH words with a registered read. Each item
// picks a queue (queue_sel_i) and an operation (mode_i): enqueue at the tail,
// dequeue the head, peek at the head, look up the first entry whose id equals
// thread_key_i, or pull that entry out while the rest keep their order. Each
// item yields exactly one result carrying status, the returned entry (found_o,
// handle_out_o, id_out_o, zero when nothing is returned) and the selected
// queue's count after the operation (zero for an invalid queue). queue_limit
// is written through cfg_we_i / cfg_wdata_i; the user must write it only while
// the block is idle, and the block itself does not enforce this. Zero means the
// queue is bounded only by QUEUE_DEPTH. Items are handled one at a time by a
// sequencer walking the memory; a pull's scan up to the match and its
// compaction behind it share the memory ports one entry per cycle. A finished
// result sits in the output register while the next item is already accepted
// and worked on. The memory needs no clearing pass: only live slots are ever
// read.
module thread_status_queues_unit #(
  parameter int NUM_QUEUES  = tsq_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = tsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tsq_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tsq_pkg::MODE_W-1:0]    mode_i,
  input  logic [tsq_pkg::QSEL_W-1:0]    queue_sel_i,
  input  logic [tsq_pkg::KEY_W-1:0]     thread_key_i,
  input  logic [tsq_pkg::HANDLE_W-1:0]  handle_in_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tsq_pkg::STATUS_W-1:0]  status_o,
  output logic                          found_o,
  output logic [tsq_pkg::HANDLE_W-1:0]  handle_out_o,
  output logic [tsq_pkg::KEY_W-1:0]     id_out_o,
  output logic [tsq_pkg::COUNT_W-1:0]   queue_count_o
);

  // ring position, count, queue index and memory address widths
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);

  // sequencer
  tsq_pkg::state_e state_q, state_d;

  // latched item
  logic [tsq_pkg::MODE_W-1:0]   mode_q, mode_d;
  logic [tsq_pkg::QSEL_W-1:0]   sel_q, sel_d;
  logic [tsq_pkg::KEY_W-1:0]    key_q, key_d;
  logic [tsq_pkg::HANDLE_W-1:0] handle_q, handle_d;

  // configuration and per-queue bookkeeping
  logic [tsq_pkg::LIMIT_W-1:0] limit_q;
  logic [PW-1:0]               head_q [NUM_QUEUES];
  logic [PW-1:0]               head_d [NUM_QUEUES];
  logic [CW-1:0]               count_q [NUM_QUEUES];
  logic [CW-1:0]               count_d [NUM_QUEUES];

  // walk position: scan position, or compaction target slot
  logic [PW-1:0] pos_q, pos_d;

  // result being built
  tsq_pkg::status_e            res_status_q, res_status_d;
  logic                        res_found_q, res_found_d;
  logic [tsq_pkg::WORD_W-1:0]  res_word_q, res_word_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [tsq_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                         out_found_q, out_found_d;
  logic [tsq_pkg::WORD_W-1:0]   out_word_q, out_word_d;
  logic [tsq_pkg::COUNT_W-1:0]  out_count_q, out_count_d;

  // entry memory
  logic [tsq_pkg::WORD_W-1:0] mem [SLOTS];
  logic [tsq_pkg::WORD_W-1:0] rdata_q;
  logic                       mem_we, mem_re;
  logic [PW-1:0]              wr_pos, rd_pos;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [tsq_pkg::WORD_W-1:0] mem_wdata;

  // shared decode of the latched item
  logic          q_valid;
  logic [QW-1:0] q_idx;
  logic [CW-1:0] cnt;
  logic [PW-1:0] hd;
  logic          is_full;
  logic          next_more, next2_more;
  logic          head_only, key_hit, scan_hit;
  logic          in_accept;

  // queue base plus ring offset; the ring sum stays below twice the depth
  function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                               input logic [PW-1:0] h,
                                               input logic [PW-1:0] p);
    logic [PW:0] ring;
    ring = {1'b0, h} + {1'b0, p};
    if (ring >= (PW+1)'(QUEUE_DEPTH)) begin
      ring = ring - (PW+1)'(QUEUE_DEPTH);
    end
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(ring);
  endfunction

  assign in_ready_o = (state_q == tsq_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  assign q_valid = ({1'b0, sel_q} < (tsq_pkg::QSEL_W+1)'(NUM_QUEUES));
  assign q_idx   = sel_q[QW-1:0];
  assign cnt     = q_valid ? count_q[q_idx] : '0;
  assign hd      = q_valid ? head_q[q_idx] : '0;

  // refused when the limit register or the storage depth is reached
  assign is_full = ((limit_q != '0) && (tsq_pkg::COUNT_W'(cnt) >= limit_q))
                || (cnt >= CW'(QUEUE_DEPTH));

  // is there an entry behind the current position (one or two further)
  assign next_more  = ({1'b0, CW'(pos_q)} + (CW+1)'(1)) < {1'b0, cnt};
  assign next2_more = ({1'b0, CW'(pos_q)} + (CW+1)'(2)) < {1'b0, cnt};

  // dequeue and peek take the head unconditionally; lookup and pull match ids
  assign head_only = (mode_q == tsq_pkg::MODE_DEQ) || (mode_q == tsq_pkg::MODE_PEEK);
  assign key_hit   = (rdata_q[tsq_pkg::WORD_W-1 -: tsq_pkg::KEY_W] == key_q);
  assign scan_hit  = head_only || key_hit;

  assign mem_waddr = slot_addr(q_idx, hd, wr_pos);
  assign mem_raddr = slot_addr(q_idx, hd, rd_pos);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tsq_pkg::ST_EXEC;
        end
      end
      tsq_pkg::ST_EXEC: begin
        state_d = tsq_pkg::ST_RESP;
        if (q_valid) begin
          unique case (mode_q) inside
            tsq_pkg::MODE_DEQ, tsq_pkg::MODE_PEEK,
            tsq_pkg::MODE_LOOKUP, tsq_pkg::MODE_PULL: begin
              if (cnt != '0) begin
                state_d = tsq_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      tsq_pkg::ST_SCAN: begin
        if (scan_hit) begin
          if ((mode_q == tsq_pkg::MODE_PULL) && next_more) begin
            state_d = tsq_pkg::ST_SHIFT;
          end else begin
            state_d = tsq_pkg::ST_RESP;
          end
        end else if (!next_more) begin
          state_d = tsq_pkg::ST_RESP;
        end
      end
      tsq_pkg::ST_SHIFT: begin
        if (!next2_more) begin
          state_d = tsq_pkg::ST_RESP;
        end
      end
      tsq_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = tsq_pkg::ST_IDLE;
        end
      end
      default: state_d = tsq_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_d       = mode_q;
    sel_d        = sel_q;
    key_d        = key_q;
    handle_d     = handle_q;
    head_d       = head_q;
    count_d      = count_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_word_d   = res_word_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_word_d   = out_word_q;
    out_count_d  = out_count_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    wr_pos       = pos_q;
    rd_pos       = pos_q;
    mem_wdata    = rdata_q;

    // output register drains independently of the sequencer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tsq_pkg::ST_IDLE: begin
        if (in_accept) begin
          mode_d   = mode_i;
          sel_d    = queue_sel_i;
          key_d    = thread_key_i;
          handle_d = handle_in_i;
        end
      end
      tsq_pkg::ST_EXEC: begin
        res_status_d = tsq_pkg::STATUS_OK;
        res_found_d  = 1'b0;
        res_word_d   = '0;
        pos_d        = '0;
        if (!q_valid) begin
          res_status_d = tsq_pkg::STATUS_INVALID;
        end else begin
          unique case (mode_q) inside
            tsq_pkg::MODE_ENQ: begin
              if (is_full) begin
                res_status_d = tsq_pkg::STATUS_FULL;
              end else begin
                mem_we          = 1'b1;
                wr_pos          = PW'(cnt);
                mem_wdata       = {key_q, handle_q};
                count_d[q_idx]  = cnt + CW'(1);
              end
            end
            tsq_pkg::MODE_DEQ, tsq_pkg::MODE_PEEK: begin
              if (cnt == '0) begin
                res_status_d = tsq_pkg::STATUS_EMPTY;
              end else begin
                mem_re = 1'b1;
                rd_pos = '0;
              end
            end
            tsq_pkg::MODE_LOOKUP, tsq_pkg::MODE_PULL: begin
              if (cnt == '0) begin
                res_status_d = tsq_pkg::STATUS_NOT_FOUND;
              end else begin
                mem_re = 1'b1;
                rd_pos = '0;
              end
            end
            default: ;  // unknown operation leaves everything alone
          endcase
        end
      end
      tsq_pkg::ST_SCAN: begin
        // rdata_q holds the entry at pos_q
        if (scan_hit) begin
          res_found_d = 1'b1;
          res_word_d  = rdata_q;
          if (mode_q == tsq_pkg::MODE_DEQ) begin
            head_d[q_idx]  = (hd == PW'(QUEUE_DEPTH - 1)) ? '0 : hd + PW'(1);
            count_d[q_idx] = cnt - CW'(1);
          end else if (mode_q == tsq_pkg::MODE_PULL) begin
            if (next_more) begin
              // start compaction: fetch the follower, pos_q stays the target
              mem_re = 1'b1;
              rd_pos = pos_q + PW'(1);
            end else begin
              count_d[q_idx] = cnt - CW'(1);
            end
          end
        end else if (next_more) begin
          mem_re = 1'b1;
          rd_pos = pos_q + PW'(1);
          pos_d  = pos_q + PW'(1);
        end else begin
          res_status_d = tsq_pkg::STATUS_NOT_FOUND;
        end
      end
      tsq_pkg::ST_SHIFT: begin
        // rdata_q holds the entry at pos_q + 1; move it down one slot
        mem_we    = 1'b1;
        wr_pos    = pos_q;
        mem_wdata = rdata_q;
        if (next2_more) begin
          mem_re = 1'b1;
          rd_pos = pos_q + PW'(1) + PW'(1);
          pos_d  = pos_q + PW'(1);
        end else begin
          count_d[q_idx] = cnt - CW'(1);
        end
      end
      tsq_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_word_d   = res_word_q;
          out_count_d  = tsq_pkg::COUNT_W'(cnt);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsq_pkg::ST_IDLE;
      limit_q     <= '0;
      head_q      <= '{default: '0};
      count_q     <= '{default: '0};
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    sel_q        <= sel_d;
    key_q        <= key_d;
    handle_q     <= handle_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_word_q   <= res_word_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_word_q   <= out_word_d;
    out_count_q  <= out_count_d;
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign handle_out_o  = out_word_q[tsq_pkg::HANDLE_W-1:0];
  assign id_out_o      = out_word_q[tsq_pkg::WORD_W-1 -: tsq_pkg::KEY_W];
  assign queue_count_o = out_count_q;

`ifndef NO_ASSERTIONS
  // an accepted item always starts execution on the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == tsq_pkg::ST_EXEC))
    else $error("accepted item did not start execution");

  // the walk never runs past the live entries of the queue
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tsq_pkg::ST_SCAN) || (state_q == tsq_pkg::ST_SHIFT))
      |-> (q_valid && (CW'(pos_q) < cnt)))
    else $error("walk position beyond queue count");

  // memory is written only by enqueue or by compaction
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == tsq_pkg::ST_EXEC) || (state_q == tsq_pkg::ST_SHIFT)))
    else $error("memory write outside enqueue or compaction");

  // a queue count never exceeds the storage depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsq_pkg::ST_RESP) |-> (cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue count above depth");
`endif

endmodule

// ===== dv/thread_status_queues_unit_tb.sv =====
// self-checking testbench for thread_status_queues_unit
// depends on tsq_pkg and the thread_status_queues_unit rtl; needs no files at run time
module thread_status_queues_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_QUEUES    = tsq_pkg::NUM_QUEUES_DEF;
  localparam int QUEUE_DEPTH   = tsq_pkg::QUEUE_DEPTH_DEF;
  // settle time covers the longest item, such as a pull over a full queue, plus margin
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 60;
  // id bits inside a stored word
  localparam int ID_MSB        = tsq_pkg::WORD_W - 1;
  localparam int ID_LSB        = tsq_pkg::HANDLE_W;

  // operation codes the block treats as no-ops
  localparam logic [tsq_pkg::MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
  localparam logic [tsq_pkg::MODE_W-1:0] MODE_RSVD_LAST  = 3'd7;
  // first and last queue select past the implemented queues
  localparam logic [tsq_pkg::QSEL_W-1:0] QSEL_BAD_FIRST  = tsq_pkg::QSEL_W'(NUM_QUEUES);
  localparam logic [tsq_pkg::QSEL_W-1:0] QSEL_BAD_LAST   = '1;

  // one result item as the block should report it
  typedef struct packed {
    tsq_pkg::status_e               status;
    logic                           found;
    logic [tsq_pkg::HANDLE_W-1:0]   handle;
    logic [tsq_pkg::KEY_W-1:0]      id;
    logic [tsq_pkg::COUNT_W-1:0]    count;
  } reply_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tsq_pkg::LIMIT_W-1:0]   cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [tsq_pkg::MODE_W-1:0]    mode_i;
  logic [tsq_pkg::QSEL_W-1:0]    queue_sel_i;
  logic [tsq_pkg::KEY_W-1:0]     thread_key_i;
  logic [tsq_pkg::HANDLE_W-1:0]  handle_in_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [tsq_pkg::STATUS_W-1:0]  status_o;
  logic                          found_o;
  logic [tsq_pkg::HANDLE_W-1:0]  handle_out_o;
  logic [tsq_pkg::KEY_W-1:0]     id_out_o;
  logic [tsq_pkg::COUNT_W-1:0]   queue_count_o;

  thread_status_queues_unit #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .queue_sel_i   (queue_sel_i),
    .thread_key_i  (thread_key_i),
    .handle_in_i   (handle_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .handle_out_o  (handle_out_o),
    .id_out_o      (id_out_o),
    .queue_count_o (queue_count_o)
  );

  // shadow copy of the queues: ring storage, head slot and fill per queue
  logic [tsq_pkg::WORD_W-1:0]   ring_mem [NUM_QUEUES][QUEUE_DEPTH];
  int unsigned                  head_ptr [NUM_QUEUES];
  int unsigned                  fill_cnt [NUM_QUEUES];
  logic [tsq_pkg::LIMIT_W-1:0]  limit_reg;

  // replies owed by the block, oldest first
  reply_t pending_replies [$];
  reply_t last_reply;

  // handshake shaping
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;

  // bookkeeping
  int error_count;
  int reports;
  int items_sent;
  int replies_checked;
  int status_hits [5];
  longint cycle_cnt;

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("%0t timeout after %0d cycles, %0d replies outstanding", $time, cycle_cnt,
                 pending_replies.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one operation to the shadow queues, returns the reply
  // ---------------------------------------------------------------------------
  function automatic reply_t run_queue_op(input logic [tsq_pkg::MODE_W-1:0] m,
                                          input logic [tsq_pkg::QSEL_W-1:0] q,
                                          input logic [tsq_pkg::KEY_W-1:0] k,
                                          input logic [tsq_pkg::HANDLE_W-1:0] h);
    reply_t       r;
    int unsigned  cnt;
    int           pos;
    logic [tsq_pkg::WORD_W-1:0] word;
    r = '0;
    r.status = tsq_pkg::STATUS_OK;
    // invalid queue: INVALID status, all other fields zero, nothing touched
    if (q >= NUM_QUEUES) begin
      r.status = tsq_pkg::STATUS_INVALID;
      return r;
    end
    cnt  = fill_cnt[q];
    pos  = -1;
    word = '0;
    case (m) inside
      tsq_pkg::MODE_ENQ: begin
        // a limit above the depth behaves like the depth
        if ((limit_reg != 0 && cnt >= limit_reg) || cnt >= QUEUE_DEPTH) begin
          r.status = tsq_pkg::STATUS_FULL;
        end else begin
          ring_mem[q][(head_ptr[q] + cnt) % QUEUE_DEPTH] = {k, h};
          fill_cnt[q] = cnt + 1;
        end
      end
      tsq_pkg::MODE_DEQ, tsq_pkg::MODE_PEEK: begin
        if (cnt == 0) begin
          r.status = tsq_pkg::STATUS_EMPTY;
        end else begin
          word = ring_mem[q][head_ptr[q]];
          r.found = 1'b1;
          if (m == tsq_pkg::MODE_DEQ) begin
            head_ptr[q] = (head_ptr[q] + 1) % QUEUE_DEPTH;
            fill_cnt[q] = cnt - 1;
          end
        end
      end
      tsq_pkg::MODE_LOOKUP, tsq_pkg::MODE_PULL: begin
        // first match counted from the head
        for (int i = 0; i < cnt; i++) begin
          if (pos < 0 && ring_mem[q][(head_ptr[q] + i) % QUEUE_DEPTH][ID_MSB:ID_LSB] == k)
            pos = i;
        end
        if (pos < 0) begin
          r.status = tsq_pkg::STATUS_NOT_FOUND;
        end else begin
          word = ring_mem[q][(head_ptr[q] + pos) % QUEUE_DEPTH];
          r.found = 1'b1;
          if (m == tsq_pkg::MODE_PULL) begin
            // close the gap, entries behind the match slide one slot forward
            for (int i = pos; i + 1 < cnt; i++)
              ring_mem[q][(head_ptr[q] + i) % QUEUE_DEPTH] =
                ring_mem[q][(head_ptr[q] + i + 1) % QUEUE_DEPTH];
            fill_cnt[q] = cnt - 1;
          end
        end
      end
      default: ;  // reserved operations leave everything alone
    endcase
    r.handle = word[tsq_pkg::HANDLE_W-1:0];
    r.id     = word[ID_MSB:ID_LSB];
    r.count  = tsq_pkg::COUNT_W'(fill_cnt[q]);
    return r;
  endfunction

  // id of a live entry anywhere in the queue, so lookups and pulls hit
  function automatic logic [tsq_pkg::KEY_W-1:0] live_id(input int unsigned q);
    int unsigned p;
    p = $urandom_range(0, fill_cnt[q] - 1);
    return ring_mem[q][(head_ptr[q] + p) % QUEUE_DEPTH][ID_MSB:ID_LSB];
  endfunction

  // half the time a live id when the queue has entries, else a narrow range for duplicates, else anything
  function automatic logic [tsq_pkg::KEY_W-1:0] pick_key(input logic [tsq_pkg::QSEL_W-1:0] q);
    if (q < NUM_QUEUES && fill_cnt[q] > 0 && $urandom_range(0, 1))
      return live_id(q);
    if ($urandom_range(0, 1))
      return tsq_pkg::KEY_W'($urandom_range(0, 7));
    return tsq_pkg::KEY_W'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // item driver: optional gap, then hold the item until the block takes it
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [tsq_pkg::MODE_W-1:0] m,
                           input logic [tsq_pkg::QSEL_W-1:0] q,
                           input logic [tsq_pkg::KEY_W-1:0] k,
                           input logic [tsq_pkg::HANDLE_W-1:0] h);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    queue_sel_i  <= q;
    thread_key_i <= k;
    handle_in_i  <= h;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge: predict in acceptance order
    last_reply = run_queue_op(m, q, k, h);
    pending_replies.push_back(last_reply);
    items_sent++;
  endtask

  // random item; enq_pct steers toward filling or emptying the queues
  task automatic send_random_item(input int enq_pct);
    logic [tsq_pkg::MODE_W-1:0] m;
    logic [tsq_pkg::QSEL_W-1:0] q;
    int roll;
    if ($urandom_range(0, 19) == 0)
      q = tsq_pkg::QSEL_W'($urandom_range(QSEL_BAD_FIRST, QSEL_BAD_LAST));
    else
      q = tsq_pkg::QSEL_W'($urandom_range(0, NUM_QUEUES - 1));
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) begin
      m = tsq_pkg::MODE_ENQ;
    end else if (roll < 95) begin
      case ($urandom_range(0, 3))
        0: m = tsq_pkg::MODE_DEQ;
        1: m = tsq_pkg::MODE_PEEK;
        2: m = tsq_pkg::MODE_LOOKUP;
        default: m = tsq_pkg::MODE_PULL;
      endcase
    end else begin
      m = tsq_pkg::MODE_W'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
    end
    send_item(m, q, pick_key(q), tsq_pkg::HANDLE_W'($urandom));
  endtask

  // drop valid and wait out every owed reply, then let the sequencer settle
  task automatic wait_for_all_replies();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // limit register: only touched with the block idle
  task automatic write_queue_limit(input logic [tsq_pkg::LIMIT_W-1:0] v);
    wait_for_all_replies();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_reg = v;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random ready, plus a long hold-off when asked for
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // compare each accepted result against the oldest owed reply
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        error_count++;
        if (reports < MAX_REPORTS)
          $display("%0t unexpected result: status %0d found %0d handle %h id %h count %0d",
                   $time, status_o, found_o, handle_out_o, id_out_o, queue_count_o);
        reports++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (status_o != want.status || found_o != want.found ||
            handle_out_o != want.handle || id_out_o != want.id ||
            queue_count_o != want.count) begin
          error_count++;
          // fields in order: status/found/handle/id/count
          if (reports < MAX_REPORTS)
            $display("%0t mismatch: expected %0d/%0d/%h/%h/%0d, actual %0d/%0d/%h/%h/%0d",
                     $time, want.status, want.found, want.handle, want.id, want.count,
                     status_o, found_o, handle_out_o, id_out_o, queue_count_o);
          reports++;
        end
        if (status_o <= tsq_pkg::STATUS_INVALID) status_hits[status_o]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every operation, and the corner cases by hand
  task automatic test_directed_cases();
    // invalid queue at both ends of the bad range
    send_item(tsq_pkg::MODE_ENQ,  QSEL_BAD_LAST,  8'hff, 16'hffff);
    send_item(tsq_pkg::MODE_DEQ,  QSEL_BAD_FIRST, 8'h00, 16'h0000);
    // empty queues: dequeue and peek report empty, searches report not found
    send_item(tsq_pkg::MODE_DEQ,    3'd0, 8'h00, 16'h0000);
    send_item(tsq_pkg::MODE_PEEK,   3'd1, 8'h00, 16'h0000);
    send_item(tsq_pkg::MODE_LOOKUP, 3'd2, 8'h00, 16'h0000);
    send_item(tsq_pkg::MODE_PULL,   3'd3, 8'hff, 16'hffff);
    // extreme ids and handles, with a repeated id
    send_item(tsq_pkg::MODE_ENQ, 3'd0, 8'h00, 16'h0000);
    send_item(tsq_pkg::MODE_ENQ, 3'd0, 8'hff, 16'hffff);
    send_item(tsq_pkg::MODE_ENQ, 3'd0, 8'h5a, 16'ha5a5);
    send_item(tsq_pkg::MODE_ENQ, 3'd0, 8'hff, 16'h0001);
    send_item(tsq_pkg::MODE_PEEK,   3'd0, 8'h00, 16'h0000);
    // first match wins over the later duplicate
    send_item(tsq_pkg::MODE_LOOKUP, 3'd0, 8'hff, 16'h0000);
    send_item(tsq_pkg::MODE_LOOKUP, 3'd0, 8'h77, 16'h0000);
    // pull from the middle, order of the rest kept
    send_item(tsq_pkg::MODE_PULL,   3'd0, 8'h5a, 16'h0000);
    send_item(tsq_pkg::MODE_PULL,   3'd0, 8'h5a, 16'h0000);
    // reserved operations change nothing
    send_item(MODE_RSVD_FIRST, 3'd0, 8'h00, 16'h0000);
    send_item(MODE_RSVD_LAST,  3'd3, 8'hff, 16'hffff);
    send_item(MODE_RSVD_LAST,  QSEL_BAD_LAST, 8'h00, 16'h0000);
    send_item(tsq_pkg::MODE_DEQ, 3'd0, 8'h00, 16'h0000);
    send_item(tsq_pkg::MODE_DEQ, 3'd0, 8'h00, 16'h0000);
    send_item(tsq_pkg::MODE_DEQ, 3'd0, 8'h00, 16'h0000);
    send_item(tsq_pkg::MODE_DEQ, 3'd0, 8'h00, 16'h0000);
  endtask

  // fill one queue per limit setting until refused, then empty it again
  task automatic test_queue_limits();
    logic [tsq_pkg::LIMIT_W-1:0] limits [5] = '{5'd1, 5'd3, 5'd16, 5'd31, 5'd0};
    logic [tsq_pkg::QSEL_W-1:0] q;
    for (int s = 0; s < 5; s++) begin
      write_queue_limit(limits[s]);
      q = tsq_pkg::QSEL_W'(s % NUM_QUEUES);
      for (int n = 0; n <= QUEUE_DEPTH; n++) begin
        send_item(tsq_pkg::MODE_ENQ, q, tsq_pkg::KEY_W'($urandom_range(0, 15)),
                  tsq_pkg::HANDLE_W'($urandom));
        if (last_reply.status == tsq_pkg::STATUS_FULL) break;
      end
      // mix of pulls anywhere in the ring and plain dequeues
      while (fill_cnt[q] > 0) begin
        if ($urandom_range(0, 1))
          send_item(tsq_pkg::MODE_PULL, q, live_id(q), tsq_pkg::HANDLE_W'($urandom));
        else
          send_item(tsq_pkg::MODE_DEQ, q, tsq_pkg::KEY_W'($urandom),
                    tsq_pkg::HANDLE_W'($urandom));
      end
    end
  endtask

  // receiver stalls long while items keep coming, so the block backs up
  task automatic test_output_stall();
    int saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    hold_left = 150;
    repeat (12) send_random_item(50);
    send_idle_pct = saved;
    // sender pauses until every reply is back
    wait_for_all_replies();
  endtask

  // random traffic: fill-heavy, then balanced, then drain-heavy
  task automatic test_random_traffic(input int s_idle, input int r_idle,
                                     input logic [tsq_pkg::LIMIT_W-1:0] lim, input int n);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    write_queue_limit(lim);
    for (int i = 0; i < n; i++)
      send_random_item(i < n / 3 ? 65 : (i < 2 * n / 3 ? 40 : 20));
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    mode_i        = tsq_pkg::MODE_ENQ;
    queue_sel_i   = '0;
    thread_key_i  = '0;
    handle_in_i   = '0;
    send_idle_pct = 38;
    recv_idle_pct = 63;
    hold_left     = 0;
    error_count   = 0;
    reports       = 0;
    items_sent    = 0;
    replies_checked = 0;
    limit_reg     = '0;
    foreach (status_hits[i]) status_hits[i] = 0;
    foreach (head_ptr[i]) begin
      head_ptr[i] = 0;
      fill_cnt[i] = 0;
    end

    // reset held low, then released on a clock edge
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_queue_limits();
    test_output_stall();
    test_random_traffic(38, 63, 5'd0, 180);
    test_random_traffic(63, 38, 5'd6, 180);
    test_random_traffic(0, 0, 5'd16, 180);

    // everything back, then a quiet stretch to catch stray results
    wait_for_all_replies();

    $display("covered %0d items, %0d results checked (ok %0d, full %0d, empty %0d,",
             items_sent, replies_checked, status_hits[tsq_pkg::STATUS_OK],
             status_hits[tsq_pkg::STATUS_FULL], status_hits[tsq_pkg::STATUS_EMPTY]);
    $display("not found %0d, invalid queue %0d) over limits 0 1 3 6 16 31, %0d errors",
             status_hits[tsq_pkg::STATUS_NOT_FOUND], status_hits[tsq_pkg::STATUS_INVALID],
             error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== thread_status_queues_unit.f =====
rtl/core/tsq_pkg.sv
rtl/core/thread_status_queues_unit.sv
dv/thread_status_queues_unit_tb.sv
